/* rtl/sequenced_trace_ring_unit_assert.svh */
// Assertion macros for the sequenced trace ring unit.
`ifndef SEQUENCED_TRACE_RING_UNIT_ASSERT_SVH
`define SEQUENCED_TRACE_RING_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define STRACE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("trace ring assertion failed");

`define STRACE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("trace ring assertion failed");

`else

`define STRACE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define STRACE_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/strace_pkg.sv */
// Shared types, constants and helpers of the sequenced trace ring.
`default_nettype none

package strace_pkg;

	// ring depth, a power of two
	localparam int RING_DEPTH = 64;
	localparam int IDX_W = $clog2(RING_DEPTH);
	localparam logic [63:0] DEPTH_W = 64'(RING_DEPTH);

	localparam logic [2:0] SEV_ERROR = 3'd3;
	localparam logic [2:0] THRESH_RESET = 3'd6;
	localparam logic REQ_APPEND = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic finish_read;
	} cmd_t;

	typedef struct packed {
		logic is_read;
	} status_t;

	typedef struct packed {
		logic [63:0] seq;
		logic [63:0] stamp;
		logic [2:0]  sev;
		logic [63:0] msg;
	} rec_t;

	function automatic logic [63:0] oldest_of(input logic [63:0] cnt);
		logic [63:0] res;
		res = (cnt > DEPTH_W) ? (cnt - DEPTH_W) : 64'd0;
		return res;
	endfunction

endpackage

`default_nettype wire

/* rtl/strace_dp.sv */
// Datapath: ring memory, counters, threshold and result registers.
`default_nettype none

module strace_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire strace_pkg::cmd_t     cmd,
	output strace_pkg::status_t       status,
	input  wire logic                 cfg_we,
	input  wire logic [2:0]           cfg_data,
	input  wire logic                 req_type,
	input  wire logic [3:0]           severity,
	input  wire logic [63:0]          clock_ns,
	input  wire logic [63:0]          message_word,
	input  wire logic [63:0]          wanted_sequence,
	output logic                      console_emit,
	output logic [63:0]               assigned_sequence,
	output logic [63:0]               stamped_time,
	output logic                      read_ok,
	output logic [2:0]                read_severity,
	output logic [63:0]               read_time,
	output logic [63:0]               read_message,
	output logic [63:0]               oldest_retained,
	output logic [63:0]               next_to_assign
);

	strace_pkg::rec_t mem [strace_pkg::RING_DEPTH];

	logic [strace_pkg::RING_DEPTH-1:0] valid_q;
	logic [63:0] seq_cnt_q;
	logic [63:0] last_time_q;
	logic [2:0]  thresh_q;

	strace_pkg::rec_t rd_rec_q;
	logic        rd_vld_q;
	logic        range_ok_q;
	logic [63:0] want_q;

	logic        do_append;
	logic [2:0]  sev_map;
	logic [63:0] stamp_new;
	logic [63:0] cnt_next;
	logic [63:0] oldest_now;
	logic [strace_pkg::IDX_W-1:0] wr_idx;
	logic [strace_pkg::IDX_W-1:0] rd_idx;
	logic        hit;

	assign status.is_read = req_type;

	assign do_append  = cmd.accept && (req_type == strace_pkg::REQ_APPEND);
	assign sev_map    = (severity > 4'd7) ? strace_pkg::SEV_ERROR : severity[2:0];
	assign stamp_new  = (clock_ns < last_time_q) ? last_time_q : clock_ns;
	assign cnt_next   = seq_cnt_q + 64'd1;
	assign oldest_now = strace_pkg::oldest_of(seq_cnt_q);
	assign wr_idx     = seq_cnt_q[strace_pkg::IDX_W-1:0];
	assign rd_idx     = wanted_sequence[strace_pkg::IDX_W-1:0];
	assign hit        = rd_vld_q && range_ok_q && (rd_rec_q.seq == want_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			seq_cnt_q   <= 64'd0;
			last_time_q <= 64'd0;
			thresh_q    <= strace_pkg::THRESH_RESET;
		end else begin
			if (cfg_we) begin
				thresh_q <= cfg_data;
			end
			if (do_append) begin
				valid_q[wr_idx] <= 1'b1;
				seq_cnt_q       <= cnt_next;
				last_time_q     <= stamp_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_append) begin
			mem[wr_idx] <= '{seq: seq_cnt_q, stamp: stamp_new, sev: sev_map,
				msg: message_word};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_rec_q   <= mem[rd_idx];
			rd_vld_q   <= valid_q[rd_idx];
			want_q     <= wanted_sequence;
			range_ok_q <= (wanted_sequence >= oldest_now) && (wanted_sequence < seq_cnt_q);
		end
	end

	always_ff @(posedge clk) begin
		if (do_append) begin
			console_emit      <= (sev_map <= thresh_q);
			assigned_sequence <= seq_cnt_q;
			stamped_time      <= stamp_new;
			read_ok           <= 1'b0;
			read_severity     <= 3'd0;
			read_time         <= 64'd0;
			read_message      <= 64'd0;
			oldest_retained   <= strace_pkg::oldest_of(cnt_next);
			next_to_assign    <= cnt_next;
		end else if (cmd.finish_read) begin
			console_emit      <= 1'b0;
			assigned_sequence <= 64'd0;
			stamped_time      <= 64'd0;
			read_ok           <= hit;
			read_severity     <= hit ? rd_rec_q.sev : 3'd0;
			read_time         <= hit ? rd_rec_q.stamp : 64'd0;
			read_message      <= hit ? rd_rec_q.msg : 64'd0;
			oldest_retained   <= oldest_now;
			next_to_assign    <= seq_cnt_q;
		end
	end

endmodule

`default_nettype wire

/* rtl/strace_ctrl.sv */
// Controller: one request in flight, lookup wait and result hold.
`default_nettype none

`include "sequenced_trace_ring_unit_assert.svh"

module strace_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	output logic                     out_valid,
	input  wire logic                out_stall,
	input  wire strace_pkg::status_t status,
	output strace_pkg::cmd_t         cmd
);

	strace_pkg::state_t state_q;
	strace_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= strace_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		in_stall        = 1'b1;
		out_valid       = 1'b0;
		cmd.accept      = 1'b0;
		cmd.finish_read = 1'b0;
		unique case (state_q)
			strace_pkg::ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = status.is_read ? strace_pkg::ST_LOOKUP : strace_pkg::ST_DONE;
				end
			end
			strace_pkg::ST_LOOKUP: begin
				cmd.finish_read = 1'b1;
				state_d         = strace_pkg::ST_DONE;
			end
			strace_pkg::ST_DONE: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					state_d = strace_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = strace_pkg::ST_IDLE;
			end
		endcase
	end

	`STRACE_ASSERT_IMP(a_one_in_flight, clk, arst_n, !in_stall, !out_valid)
	`STRACE_ASSERT_NXT(a_read_looks_up, clk, arst_n, cmd.accept && status.is_read,
		state_q == strace_pkg::ST_LOOKUP)
	`STRACE_ASSERT_NXT(a_append_result, clk, arst_n, cmd.accept && !status.is_read, out_valid)
	`STRACE_ASSERT_NXT(a_lookup_result, clk, arst_n, cmd.finish_read, out_valid)

endmodule

`default_nettype wire

/* rtl/sequenced_trace_ring_unit.sv */
// Results: an append's result is valid the cycle after its transfer; a read goes through
// the lookup state, and its result is then valid in the done state. One request in flight:
// the next is taken only once the controller has handed off its one held result.
// Reset: sequence counter and last timestamp cleared, console threshold 6, per-slot
// valid bits cleared at once, so the ring reads as empty with no clearing pass.
// Top level of the sequenced trace ring.
`default_nettype none

module sequenced_trace_ring_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        req_type,
	input  wire logic [3:0]  severity,
	input  wire logic [63:0] clock_ns,
	input  wire logic [63:0] message_word,
	input  wire logic [63:0] wanted_sequence,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             console_emit,
	output logic [63:0]      assigned_sequence,
	output logic [63:0]      stamped_time,
	output logic             read_ok,
	output logic [2:0]       read_severity,
	output logic [63:0]      read_time,
	output logic [63:0]      read_message,
	output logic [63:0]      oldest_retained,
	output logic [63:0]      next_to_assign,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_data
);

	strace_pkg::cmd_t    cmd;
	strace_pkg::status_t status;

	assign cfg_ready = 1'b1;

	strace_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	strace_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.cfg_we            (cfg_valid && cfg_ready),
		.cfg_data          (cfg_data),
		.req_type          (req_type),
		.severity          (severity),
		.clock_ns          (clock_ns),
		.message_word      (message_word),
		.wanted_sequence   (wanted_sequence),
		.console_emit      (console_emit),
		.assigned_sequence (assigned_sequence),
		.stamped_time      (stamped_time),
		.read_ok           (read_ok),
		.read_severity     (read_severity),
		.read_time         (read_time),
		.read_message      (read_message),
		.oldest_retained   (oldest_retained),
		.next_to_assign    (next_to_assign)
	);

endmodule

`default_nettype wire
